/* rtl/core/mme_pkg.sv */
// Package for the matrix multiply engine core.
// Holds item types, opcode, register index and status codes, and FSM states.
// No dependencies.
package mme_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  // 8 products of up to 2^62 each, plus sign
  localparam int unsigned ACC_W   = PROD_W + 3;

  localparam logic [1:0] MODE_LOAD_A   = 2'd0;
  localparam logic [1:0] MODE_LOAD_B   = 2'd1;
  localparam logic [1:0] MODE_MULTIPLY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic [1:0]              status;
    logic                    last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } mme_state_t;

endpackage

/* rtl/core/mme_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/matrix_multiply_engine_core.sv */
// Matrix multiply engine top level: A/B element stores and a one-MAC-per-cycle sequencer.
// Depends on mme_pkg and mme_ram.
// Each product element of a multiply item is built from one MAC per cycle through
// the two store read ports, then the multiply, accumulate and scale stages;
// a dimension mismatch gives a single mismatch result.
// Reset sets all dimension registers to 3 and clears control state; store contents stay undefined.
module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mme_pkg::in_item_t             item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mme_pkg::out_item_t            result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data
);

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);
  localparam logic [mme_pkg::DIM_W-1:0] CAP = mme_pkg::DIM_W'(DIM_CAP);
  localparam logic [mme_pkg::DIM_W:0] MAX_IDX = (mme_pkg::DIM_W + 1)'(MAX_DIM);
  localparam int unsigned ACC_W = mme_pkg::ACC_W;
  localparam int unsigned VAL_W = mme_pkg::VAL_W;

  logic [mme_pkg::DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [mme_pkg::DIM_W-1:0] n_ra, n_ca, n_rb, n_cb;

  mme_pkg::mme_state_t state, state_next;
  logic [mme_pkg::IDX_W-1:0] i, j, k;
  logic                      mism;

  logic                      item_acc, in_range, we_a, we_b;
  logic [ADDR_W-1:0]         waddr, raddr_a, raddr_b;
  logic                      rd_en, k_last, i_last, j_last, load_out;
  logic [VAL_W-1:0]          rdata_a, rdata_b;

  logic                      s1_v, s1_first, s1_last;
  logic                      s2_v, s2_first, s2_last;
  logic signed [mme_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc, acc_ext, scaled;
  logic                      acc_done, fits;
  logic signed [VAL_W-1:0]   fin_val;
  logic                      fin_sat;

  function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
    input logic [mme_pkg::DIM_W-1:0] d,
    input logic [mme_pkg::DIM_W-1:0] cap
  );
    logic [mme_pkg::DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = mme_pkg::DIM_W'(1);
    end else if (d > cap) begin
      r = cap;
    end
    return r;
  endfunction

  assign n_ra = clamp_dim(rows_a, CAP);
  assign n_ca = clamp_dim(cols_a, CAP);
  assign n_rb = clamp_dim(rows_b, CAP);
  assign n_cb = clamp_dim(cols_b, CAP);

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= mme_pkg::DIM_RESET;
      cols_a <= mme_pkg::DIM_RESET;
      rows_b <= mme_pkg::DIM_RESET;
      cols_b <= mme_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_A: rows_a <= cfg_data;
        mme_pkg::REG_COLS_A: cols_a <= cfg_data;
        mme_pkg::REG_ROWS_B: rows_b <= cfg_data;
        mme_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // element stores
  assign item_ready = (state == mme_pkg::ST_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign in_range   = ({2'b0, item.row} < MAX_IDX) && ({2'b0, item.col} < MAX_IDX);
  assign we_a  = item_acc && in_range && (item.mode == mme_pkg::MODE_LOAD_A);
  assign we_b  = item_acc && in_range && (item.mode == mme_pkg::MODE_LOAD_B);
  assign waddr = ADDR_W'(item.row) * DIM_A + ADDR_W'(item.col);

  assign raddr_a = ADDR_W'(i) * DIM_A + ADDR_W'(k);
  assign raddr_b = ADDR_W'(k) * DIM_A + ADDR_W'(j);

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (item.value),
    .re    (rd_en),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (item.value),
    .re    (rd_en),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign k_last = ({1'b0, k} == n_ca - mme_pkg::DIM_W'(1));
  assign i_last = ({1'b0, i} == n_ra - mme_pkg::DIM_W'(1));
  assign j_last = ({1'b0, j} == n_cb - mme_pkg::DIM_W'(1));

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      mme_pkg::ST_IDLE: begin
        if (item_acc && item.mode == mme_pkg::MODE_MULTIPLY) begin
          state_next = (n_ca != n_rb) ? mme_pkg::ST_EMIT : mme_pkg::ST_ISSUE;
        end
      end
      mme_pkg::ST_ISSUE: begin
        rd_en = 1'b1;
        if (k_last) begin
          state_next = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (acc_done) begin
          state_next = mme_pkg::ST_EMIT;
        end
      end
      mme_pkg::ST_EMIT: begin
        if (!result_valid || result_ready) begin
          load_out = 1'b1;
          if (mism || (i_last && j_last)) begin
            state_next = mme_pkg::ST_IDLE;
          end else begin
            state_next = mme_pkg::ST_ISSUE;
          end
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      mism  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mme_pkg::ST_IDLE && item_acc && item.mode == mme_pkg::MODE_MULTIPLY) begin
        mism <= (n_ca != n_rb);
        i    <= '0;
        j    <= '0;
        k    <= '0;
      end else if (rd_en) begin
        k <= k + 1'b1;
      end else if (load_out && !mism) begin
        k <= '0;
        if (j_last) begin
          j <= '0;
          i <= i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end
    end
  end

  // multiply-accumulate pipeline
  assign acc_ext = ACC_W'(prod);
  assign scaled  = acc >>> FRAC_BITS;
  assign fits    = (&scaled[ACC_W-1:VAL_W-1]) || !(|scaled[ACC_W-1:VAL_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_v     <= rd_en;
      s2_v     <= s1_v;
      acc_done <= s2_v && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_last  <= k_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    if (s1_v) begin
      prod <= $signed(rdata_a) * $signed(rdata_b);
    end
    if (s2_v) begin
      acc <= s2_first ? acc_ext : acc + acc_ext;
    end
    if (acc_done) begin
      fin_sat <= !fits;
      if (fits) begin
        fin_val <= scaled[VAL_W-1:0];
      end else if (acc[ACC_W-1]) begin
        fin_val <= {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        fin_val <= {1'b0, {(VAL_W-1){1'b1}}};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (mism) begin
        result.out_row   <= '0;
        result.out_col   <= '0;
        result.out_value <= '0;
        result.status    <= mme_pkg::STATUS_MISMATCH;
        result.last      <= 1'b1;
      end else begin
        result.out_row   <= i;
        result.out_col   <= j;
        result.out_value <= fin_val;
        result.status    <= fin_sat ? mme_pkg::STATUS_SAT : mme_pkg::STATUS_OK;
        result.last      <= i_last && j_last;
      end
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine_core: loads, multiplies, dimension setups.
// Predicts each product element with exact Q16.16 sums; depends on mme_pkg and the core RTL.
module tb;

  localparam int DIM        = 8;
  localparam int FRAC       = 16;
  localparam int DRAIN      = 16;
  localparam int RAND_ITEMS = 480;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                      is_cfg;
    logic [mme_pkg::DIM_W-1:0] ra;
    logic [mme_pkg::DIM_W-1:0] ca;
    logic [mme_pkg::DIM_W-1:0] rb;
    logic [mme_pkg::DIM_W-1:0] cb;
    mme_pkg::in_item_t         stim;
    logic                      typed;
    mme_pkg::out_item_t        want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_ready;
  mme_pkg::in_item_t             item = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  mme_pkg::out_item_t            result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index = mme_pkg::REG_ROWS_A;
  logic [mme_pkg::DIM_W-1:0]     cfg_data = '0;

  logic signed [mme_pkg::VAL_W-1:0] mat_a [DIM*DIM];
  logic signed [mme_pkg::VAL_W-1:0] mat_b [DIM*DIM];
  bit                               a_set [DIM*DIM];
  bit                               b_set [DIM*DIM];
  logic [mme_pkg::DIM_W-1:0]        dim_ra = mme_pkg::DIM_RESET;
  logic [mme_pkg::DIM_W-1:0]        dim_ca = mme_pkg::DIM_RESET;
  logic [mme_pkg::DIM_W-1:0]        dim_rb = mme_pkg::DIM_RESET;
  logic [mme_pkg::DIM_W-1:0]        dim_cb = mme_pkg::DIM_RESET;

  mme_pkg::out_item_t expected_products[$];
  mme_pkg::out_item_t head_product;
  dir_row_t           plan[$];
  int                 errors = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  int                 ready_age = 0;
  int                 ready_mode = 0;
  int                 stall_left = 0;

  always #5 clk = ~clk;

  matrix_multiply_engine_core #(
    .MAX_DIM  (DIM),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic void expect_item(mme_pkg::out_item_t m);
    expected_products = {expected_products, m};
  endfunction

  function automatic void add_row(dir_row_t d);
    plan = {plan, d};
  endfunction

  function automatic int clamp_dim(logic [mme_pkg::DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  // exact sum of A row i times B column j, floor-scaled to Q16.16, saturated
  function automatic mme_pkg::out_item_t dot_product(int i, int j, int n, bit fin);
    logic signed [mme_pkg::ACC_W-1:0]  acc;
    logic signed [mme_pkg::ACC_W-1:0]  lim;
    logic signed [mme_pkg::PROD_W-1:0] p;
    mme_pkg::out_item_t                r;
    acc = '0;
    lim = '0;
    lim[mme_pkg::VAL_W - 1 + FRAC] = 1'b1;
    for (int k = 0; k < n; k++) begin
      p = mat_a[i*DIM + k] * mat_b[k*DIM + j];
      acc = acc + p;
    end
    r.out_row = i[mme_pkg::IDX_W-1:0];
    r.out_col = j[mme_pkg::IDX_W-1:0];
    r.last = fin;
    if (acc >= lim) begin
      r.out_value = 32'h7FFF_FFFF;
      r.status = mme_pkg::STATUS_SAT;
    end else if (acc < -lim) begin
      r.out_value = 32'h8000_0000;
      r.status = mme_pkg::STATUS_SAT;
    end else begin
      r.out_value = acc[FRAC +: mme_pkg::VAL_W];
      r.status = mme_pkg::STATUS_OK;
    end
    return r;
  endfunction

  function automatic void predict(mme_pkg::in_item_t x);
    int                 ra;
    int                 ca;
    int                 rb;
    int                 cb;
    int                 idx;
    mme_pkg::out_item_t m;
    ra = clamp_dim(dim_ra);
    ca = clamp_dim(dim_ca);
    rb = clamp_dim(dim_rb);
    cb = clamp_dim(dim_cb);
    idx = x.row * DIM + x.col;
    case (x.mode)
      mme_pkg::MODE_LOAD_A: begin
        mat_a[idx] = x.value;
        a_set[idx] = 1'b1;
      end
      mme_pkg::MODE_LOAD_B: begin
        mat_b[idx] = x.value;
        b_set[idx] = 1'b1;
      end
      mme_pkg::MODE_MULTIPLY: begin
        if (ca != rb) begin
          m = '0;
          m.status = mme_pkg::STATUS_MISMATCH;
          m.last = 1'b1;
          expect_item(m);
        end else begin
          for (int i = 0; i < ra; i++)
            for (int j = 0; j < cb; j++)
              expect_item(dot_product(i, j, ca, i == ra - 1 && j == cb - 1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [mme_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      4, 5: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [mme_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'($urandom_range(9, 14));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endfunction

  function automatic dir_row_t cfg_row(logic [mme_pkg::DIM_W-1:0] ra, ca, rb, cb);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.ra = ra;
    d.ca = ca;
    d.rb = rb;
    d.cb = cb;
    return d;
  endfunction

  function automatic dir_row_t ld_row(logic [1:0] m, logic [mme_pkg::IDX_W-1:0] r, c,
                                      logic [mme_pkg::VAL_W-1:0] v);
    dir_row_t d;
    d = '0;
    d.stim.mode = m;
    d.stim.row = r;
    d.stim.col = c;
    d.stim.value = v;
    return d;
  endfunction

  // 1x1 or mismatch multiply with its single result typed in
  function automatic dir_row_t mul_row(logic [mme_pkg::VAL_W-1:0] v, logic [1:0] st);
    dir_row_t d;
    d = '0;
    d.stim.mode = mme_pkg::MODE_MULTIPLY;
    d.stim.row = 3'd5;
    d.stim.col = 3'd2;
    d.stim.value = 32'h5A5A_A5A5;
    d.typed = 1'b1;
    d.want.out_value = v;
    d.want.status = st;
    d.want.last = 1'b1;
    return d;
  endfunction

  task automatic send(mme_pkg::in_item_t x, bit typed, mme_pkg::out_item_t want);
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (typed) expect_item(want);
    else predict(x);
    if (x.mode != MODE_UNUSED) items_sent++;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_dims(logic [mme_pkg::DIM_W-1:0] ra, ca, rb, cb);
    logic [mme_pkg::DIM_W-1:0]     vals [4];
    logic [mme_pkg::CFG_IDX_W-1:0] regs [4];
    vals = '{ra, ca, rb, cb};
    regs = '{mme_pkg::REG_ROWS_A, mme_pkg::REG_COLS_A, mme_pkg::REG_ROWS_B,
             mme_pkg::REG_COLS_B};
    settle();
    cfg_valid <= 1'b1;
    for (int r = 0; r < 4; r++) begin
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (regs[r])
        mme_pkg::REG_ROWS_A: dim_ra = vals[r];
        mme_pkg::REG_COLS_A: dim_ca = vals[r];
        mme_pkg::REG_ROWS_B: dim_rb = vals[r];
        default:             dim_cb = vals[r];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load(logic [1:0] m, int r, int c);
    mme_pkg::in_item_t x;
    x.mode = m;
    x.row = r[mme_pkg::IDX_W-1:0];
    x.col = c[mme_pkg::IDX_W-1:0];
    x.value = rand_value();
    send(x, 1'b0, '0);
  endtask

  // every operand entry a multiply will read gets written first
  task automatic multiply_now();
    mme_pkg::in_item_t x;
    int                ra;
    int                ca;
    int                cb;
    ra = clamp_dim(dim_ra);
    ca = clamp_dim(dim_ca);
    cb = clamp_dim(dim_cb);
    if (ca == clamp_dim(dim_rb)) begin
      for (int i = 0; i < ra; i++)
        for (int k = 0; k < ca; k++)
          if (!a_set[i*DIM + k]) load(mme_pkg::MODE_LOAD_A, i, k);
      for (int k = 0; k < ca; k++)
        for (int j = 0; j < cb; j++)
          if (!b_set[k*DIM + j]) load(mme_pkg::MODE_LOAD_B, k, j);
    end
    x.mode = mme_pkg::MODE_MULTIPLY;
    x.row = 3'($urandom);
    x.col = 3'($urandom);
    x.value = $urandom;
    send(x, 1'b0, '0);
  endtask

  initial begin
    mme_pkg::in_item_t         x;
    logic [mme_pkg::DIM_W-1:0] ra;
    logic [mme_pkg::DIM_W-1:0] ca;
    logic [mme_pkg::DIM_W-1:0] rb;
    logic [mme_pkg::DIM_W-1:0] cb;
    int                        pick;
    int                        phase;

    add_row(cfg_row(4'd1, 4'd1, 4'd1, 4'd1));
    add_row(ld_row(mme_pkg::MODE_LOAD_A, 3'd0, 3'd0, 32'h0001_0000));
    add_row(ld_row(mme_pkg::MODE_LOAD_B, 3'd0, 3'd0, 32'h0002_0000));
    add_row(mul_row(32'h0002_0000, mme_pkg::STATUS_OK));
    add_row(ld_row(mme_pkg::MODE_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    add_row(ld_row(mme_pkg::MODE_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    add_row(mul_row(32'h7FFF_FFFF, mme_pkg::STATUS_SAT));
    add_row(ld_row(mme_pkg::MODE_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
    add_row(mul_row(32'h8000_0000, mme_pkg::STATUS_SAT));
    add_row(ld_row(mme_pkg::MODE_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
    add_row(mul_row(32'h7FFF_FFFF, mme_pkg::STATUS_SAT));
    // -1 lsb times 1 lsb floors to -1 lsb
    add_row(ld_row(mme_pkg::MODE_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    add_row(ld_row(mme_pkg::MODE_LOAD_B, 3'd0, 3'd0, 32'h0000_0001));
    add_row(mul_row(32'hFFFF_FFFF, mme_pkg::STATUS_OK));
    add_row(ld_row(MODE_UNUSED, 3'd7, 3'd7, 32'hA5A5_5A5A));
    add_row(ld_row(mme_pkg::MODE_LOAD_A, 3'd7, 3'd7, 32'h8000_0000));
    add_row(ld_row(mme_pkg::MODE_LOAD_B, 3'd7, 3'd7, 32'h7FFF_FFFF));
    // zero clamps to 1, fifteen clamps to 8
    add_row(cfg_row(4'd0, 4'd0, 4'd15, 4'd15));
    add_row(mul_row(32'h0000_0000, mme_pkg::STATUS_MISMATCH));
    add_row(cfg_row(4'd0, 4'd0, 4'd0, 4'd0));
    add_row(mul_row(32'hFFFF_FFFF, mme_pkg::STATUS_OK));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) write_dims(plan[n].ra, plan[n].ca, plan[n].rb, plan[n].cb);
      else send(plan[n].stim, plan[n].typed, plan[n].want);
    end

    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      case (phase)
        0: write_dims(4'd8, 4'd8, 4'd8, 4'd8);
        1: write_dims(4'd15, 4'd15, 4'd15, 4'd15);
        default: begin
          ra = pick_dim();
          ca = pick_dim();
          cb = pick_dim();
          rb = ($urandom_range(0, 5) == 0) ? pick_dim() : ca;
          write_dims(ra, ca, rb, cb);
        end
      endcase
      phase++;
      repeat ($urandom_range(15, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          multiply_now();
        end else if (pick < 11) begin
          x.mode = MODE_UNUSED;
          x.row = 3'($urandom);
          x.col = 3'($urandom);
          x.value = $urandom;
          send(x, 1'b0, '0);
        end else begin
          x.mode = $urandom_range(0, 1) ? mme_pkg::MODE_LOAD_B : mme_pkg::MODE_LOAD_A;
          if ($urandom_range(0, 3) == 0) begin
            x.row = 3'($urandom);
            x.col = 3'($urandom);
          end else if (x.mode == mme_pkg::MODE_LOAD_A) begin
            x.row = 3'($urandom_range(0, clamp_dim(dim_ra) - 1));
            x.col = 3'($urandom_range(0, clamp_dim(dim_ca) - 1));
          end else begin
            x.row = 3'($urandom_range(0, clamp_dim(dim_rb) - 1));
            x.col = 3'($urandom_range(0, clamp_dim(dim_cb) - 1));
          end
          x.value = rand_value();
          send(x, 1'b0, '0);
        end
      end
      multiply_now();
    end

    settle();
    if (errors == 0)
      $display("matrix_multiply_engine_core regression: pass");
    else
      $display("matrix_multiply_engine_core regression: fail");
    $finish;
  end

  // receiver: full speed, random, or single-cycle pulses between stalls
  always @(posedge clk) begin
    ready_age = (ready_age + 1) % 97;
    if (ready_age == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= 1'($urandom_range(0, 1));
      2: begin
        if (stall_left == 0) begin
          result_ready <= 1'b1;
          stall_left = $urandom_range(0, 8);
        end else begin
          result_ready <= 1'b0;
          stall_left--;
        end
      end
      default: result_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_products.size() == 0) begin
        $error("unexpected item: row %0d col %0d value 0x%0h status %0d",
               result.out_row, result.out_col, result.out_value, result.status);
        errors++;
      end else begin
        head_product = expected_products.pop_front();
        check_field("out_row", 32'(head_product.out_row), 32'(result.out_row));
        check_field("out_col", 32'(head_product.out_col), 32'(result.out_col));
        check_field("out_value", head_product.out_value, result.out_value);
        check_field("status", 32'(head_product.status), 32'(result.status));
        check_field("last", 32'(head_product.last), 32'(result.last));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("matrix_multiply_engine_core regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/matrix_multiply_engine_core.sv
tb/tb.sv
